>>> hdl/bapb_pkg.sv
// Shared types and constants for the balance angle/position blend block.
// No dependencies; every other file imports this package.
package bapb_pkg;

    localparam int C_IN_W    = 24;   // angle, position fields (Q7.16)
    localparam int C_THR_W   = 23;   // near threshold register
    localparam int C_GAIN_W  = 32;   // Q24.8 gains
    localparam int C_MC_W    = 29;   // widest serial multiplicand (9 * derivative)
    localparam int C_ACC_W   = 64;   // Q.24 sum of products
    localparam int C_Q_W     = 56;   // rounded magnitude after dropping 8 bits
    localparam int C_OUT_W   = 32;   // Q15.16 command
    localparam int C_REM_W   = 4;    // remainder of the divide by ten

    localparam logic [C_REM_W-1:0] C_DIV_TEN = 4'd10;

    localparam logic [C_ACC_W-1:0] C_RND_NEAR = 64'd128;   // half of 256
    localparam logic [C_ACC_W-1:0] C_RND_FAR  = 64'd1280;  // half of 2560

    localparam logic [C_Q_W-1:0] C_POS_LIMIT = 56'd2147483647;
    localparam logic [C_Q_W-1:0] C_NEG_LIMIT = 56'd2147483648;

    localparam logic [C_OUT_W-1:0] C_OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [C_OUT_W-1:0] C_OUT_MIN = 32'h8000_0000;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_TARGET_POSITION = 3'd0,
        REG_NEAR_THRESHOLD  = 3'd1,
        REG_ANGLE_OFFSET    = 3'd2,
        REG_ANGLE_KP_FAR    = 3'd3,
        REG_ANGLE_KD_FAR    = 3'd4,
        REG_ANGLE_KD_NEAR   = 3'd5,
        REG_POSITION_KP     = 3'd6,
        REG_POSITION_KD     = 3'd7
    } t_cfg_reg;

    // Reset values of the registers.
    localparam logic [C_IN_W-1:0]   C_RST_TARGET    = 24'd327680;
    localparam logic [C_THR_W-1:0]  C_RST_THRESHOLD = 23'd6554;
    localparam logic [C_IN_W-1:0]   C_RST_OFFSET    = 24'd262;
    localparam logic [C_GAIN_W-1:0] C_RST_AKP_FAR   = 32'd25600;
    localparam logic [C_GAIN_W-1:0] C_RST_AKD_FAR   = 32'd5120000;
    localparam logic [C_GAIN_W-1:0] C_RST_AKD_NEAR  = 32'd40960000;
    localparam logic [C_GAIN_W-1:0] C_RST_PKP       = 32'd1408;
    localparam logic [C_GAIN_W-1:0] C_RST_PKD       = 32'd3072;

    // Control from the sequencer to the serial multiply-accumulate unit.
    typedef struct packed {
        logic start;   // load gain and multiplicand, begin shifting
        logic clear;   // zero the accumulator with this start
    } t_mac_ctl;

endpackage

>>> hdl/bapb_if.sv
// Handshake channels of the blend block: input word, result word, register write.
// Depends on bapb_pkg for field widths.
interface bapb_in_if;
    import bapb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [C_IN_W-1:0]  tilt_angle;
    logic signed [C_IN_W-1:0]  position;
    modport source (output valid, output tilt_angle, output position, input ready);
    modport sink   (input valid, input tilt_angle, input position, output ready);
endinterface

interface bapb_out_if;
    import bapb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [C_OUT_W-1:0] wheel_velocity;
    logic                      near_mode;
    logic                      saturated;
    modport source (output valid, output wheel_velocity, output near_mode,
                    output saturated, input ready);
    modport sink   (input valid, input wheel_velocity, input near_mode,
                    input saturated, output ready);
endinterface

interface bapb_cfg_if;
    import bapb_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          index;
    logic [C_GAIN_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/bapb_mac.sv
// Bit-serial multiply-accumulate: unsigned gain times signed multiplicand,
// one gain bit per cycle into a 64-bit accumulator. Depends on bapb_pkg.
module bapb_mac
    import bapb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctl                  i_ctl,
    input  logic [C_GAIN_W-1:0]       i_gain,
    input  logic signed [C_MC_W-1:0]  i_mcand,
    output logic                      o_done,
    output logic signed [C_ACC_W-1:0] o_acc
);

    localparam int C_CNT_W = $clog2(C_GAIN_W);
    localparam logic [C_CNT_W-1:0] C_LAST = C_CNT_W'(C_GAIN_W - 1);

    logic                      r_busy;
    logic                      r_done;
    logic [C_CNT_W-1:0]        r_cnt;
    logic [C_GAIN_W-1:0]       r_gain;
    logic [C_ACC_W-1:0]        r_mcand;
    logic [C_ACC_W-1:0]        r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload: shift the gain right and the multiplicand left each cycle while busy.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_gain  <= i_gain;
            r_mcand <= {{(C_ACC_W-C_MC_W){i_mcand[C_MC_W-1]}}, i_mcand};
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_gain  <= r_gain >> 1;
            r_mcand <= r_mcand << 1;
            if (r_gain[0]) begin
                r_acc <= r_acc + r_mcand;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = $signed(r_acc);

endmodule

>>> hdl/bapb_div10.sv
// Bit-serial restoring divide by ten: one quotient bit per cycle, 4-bit remainder.
// Depends on bapb_pkg.
module bapb_div10
    import bapb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [C_Q_W-1:0] i_dividend,
    output logic             o_done,
    output logic [C_Q_W-1:0] o_quot
);

    localparam int C_CNT_W = $clog2(C_Q_W);
    localparam logic [C_CNT_W-1:0] C_LAST = C_CNT_W'(C_Q_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [C_CNT_W-1:0] r_cnt;
    logic [C_Q_W-1:0]   r_q;
    logic [C_REM_W-1:0] r_rem;
    logic [C_REM_W:0]   w_trial;
    logic               w_ge;

    // Bring down the next dividend bit and test against ten.
    assign w_trial = {r_rem, r_q[C_Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, C_DIV_TEN});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[C_Q_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= C_REM_W'(w_trial - {1'b0, C_DIV_TEN});
            end else begin
                r_rem <= w_trial[C_REM_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> hdl/balance_angle_position_blend.sv
// Balance angle/position blend: one velocity command word per input word.
// Each input word (tilt angle, position, Q7.16) yields one result word: a Q15.16
// wheel velocity with near-mode and saturation flags. Away from the target the
// command is (angle PD + 9 * position PD) / 2560, rounded half away from zero;
// when target minus position is below the near threshold (including any point
// past the target) it is the derivative-only angle term / 256. All products run
// through one bit-serial multiply-accumulate unit, and
// the far-mode divide by ten through a bit-serial divider, one bit per cycle.
// The serial units set how long an item takes; one item is in work at a time.
// A finished result sits in the output register, so the next word is accepted
// while it waits. The user must write registers over the config channel only
// while no item is in work; the block itself does not enforce it.
// Depends on bapb_pkg, bapb_if, bapb_mac and bapb_div10.
module balance_angle_position_blend
    import bapb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bapb_in_if.sink     i_in,
    bapb_out_if.source  o_out,
    bapb_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_MAG,
        S_ROUND,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic signed [C_IN_W-1:0] r_target;
    logic [C_THR_W-1:0]       r_threshold;
    logic signed [C_IN_W-1:0] r_offset;
    logic [C_GAIN_W-1:0]      r_akp_far;
    logic [C_GAIN_W-1:0]      r_akd_far;
    logic [C_GAIN_W-1:0]      r_akd_near;
    logic [C_GAIN_W-1:0]      r_pkp;
    logic [C_GAIN_W-1:0]      r_pkd;

    // History across ticks.
    logic signed [C_IN_W-1:0] r_prev_angle;
    logic signed [C_IN_W-1:0] r_prev_perr;

    // Per-item operands and working values.
    logic signed [C_IN_W:0]   r_ang_err;
    logic signed [C_IN_W:0]   r_ang_der;
    logic signed [C_MC_W-1:0] r_pe9;
    logic signed [C_MC_W-1:0] r_pd9;
    logic                     r_near;
    logic [1:0]               r_term;
    logic                     r_neg;
    logic [C_ACC_W-1:0]       r_mag;
    logic [C_Q_W-1:0]         r_t;

    // Output register.
    logic                     r_out_valid;
    logic [C_OUT_W-1:0]       r_wv;
    logic                     r_out_near;
    logic                     r_out_sat;

    // Operand preparation at the accept edge.
    logic signed [C_IN_W:0]   w_remaining;
    logic                     w_near;
    logic signed [C_IN_W-1:0] w_perr;
    logic signed [C_IN_W:0]   w_pder;
    logic signed [C_MC_W-1:0] w_perr_ext;
    logic signed [C_MC_W-1:0] w_pder_ext;

    // Serial unit hookup.
    t_mac_ctl                  w_mac_ctl;
    logic [C_GAIN_W-1:0]       w_gain;
    logic signed [C_MC_W-1:0]  w_mcand;
    logic                      w_mac_done;
    logic signed [C_ACC_W-1:0] w_acc;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [C_Q_W-1:0]          w_quot;

    logic                      w_accept;
    logic                      w_out_free;
    logic [C_ACC_W-1:0]        w_rounded;
    logic                      w_sat;
    logic [C_OUT_W-1:0]        w_cmd;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Remaining distance keeps all 25 bits for the mode test; the error used
    // in the position term clamps to 24 bits.
    assign w_remaining = (C_IN_W+1)'(r_target) - (C_IN_W+1)'(i_in.position);
    assign w_near      = w_remaining < $signed({2'b00, r_threshold});
    always_comb begin
        priority if (w_remaining[C_IN_W] != w_remaining[C_IN_W-1]) begin
            w_perr = w_remaining[C_IN_W] ? {1'b1, {(C_IN_W-1){1'b0}}}
                                         : {1'b0, {(C_IN_W-1){1'b1}}};
        end else begin
            w_perr = w_remaining[C_IN_W-1:0];
        end
    end
    assign w_pder     = (C_IN_W+1)'(w_perr) - (C_IN_W+1)'(r_prev_perr);
    assign w_perr_ext = C_MC_W'(w_perr);
    assign w_pder_ext = C_MC_W'(w_pder);

    // Pick gain and multiplicand for the current product. The factor nine on
    // the position term is folded into its multiplicands.
    always_comb begin
        priority if (r_near) begin
            w_gain  = r_akd_near;
            w_mcand = C_MC_W'(r_ang_der);
        end else begin
            unique case (r_term)
                2'd0: begin
                    w_gain  = r_akp_far;
                    w_mcand = C_MC_W'(r_ang_err);
                end
                2'd1: begin
                    w_gain  = r_akd_far;
                    w_mcand = C_MC_W'(r_ang_der);
                end
                2'd2: begin
                    w_gain  = r_pkp;
                    w_mcand = r_pe9;
                end
                default: begin
                    w_gain  = r_pkd;
                    w_mcand = r_pd9;
                end
            endcase
        end
    end

    assign w_mac_ctl.start = (r_state == S_LOAD);
    assign w_mac_ctl.clear = (r_term == 2'd0);
    assign w_div_start     = (r_state == S_ROUND) && !r_near;

    bapb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_gain  (w_gain),
        .i_mcand (w_mcand),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    // Round half away from zero: add half the divisor to the magnitude,
    // drop eight bits, and in far mode divide the rest by ten.
    assign w_rounded = r_mag + (r_near ? C_RND_NEAR : C_RND_FAR);

    bapb_div10 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rounded[C_ACC_W-1:C_ACC_W-C_Q_W]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Clip to the signed 32-bit range; the negative side reaches one further.
    assign w_sat = r_neg ? (r_t > C_NEG_LIMIT) : (r_t > C_POS_LIMIT);
    always_comb begin
        priority if (w_sat) begin
            w_cmd = r_neg ? C_OUT_MIN : C_OUT_MAX;
        end else if (r_neg) begin
            w_cmd = C_OUT_W'(-r_t[C_OUT_W-1:0]);
        end else begin
            w_cmd = r_t[C_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term       <= 2'd0;
            r_out_valid  <= 1'b0;
            r_target     <= C_RST_TARGET;
            r_threshold  <= C_RST_THRESHOLD;
            r_offset     <= C_RST_OFFSET;
            r_akp_far    <= C_RST_AKP_FAR;
            r_akd_far    <= C_RST_AKD_FAR;
            r_akd_near   <= C_RST_AKD_NEAR;
            r_pkp        <= C_RST_PKP;
            r_pkd        <= C_RST_PKD;
            r_prev_angle <= '0;
            r_prev_perr  <= '0;
        end else begin
            // Register writes.
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    REG_TARGET_POSITION: r_target    <= i_cfg.data[C_IN_W-1:0];
                    REG_NEAR_THRESHOLD:  r_threshold <= i_cfg.data[C_THR_W-1:0];
                    REG_ANGLE_OFFSET:    r_offset    <= i_cfg.data[C_IN_W-1:0];
                    REG_ANGLE_KP_FAR:    r_akp_far   <= i_cfg.data;
                    REG_ANGLE_KD_FAR:    r_akd_far   <= i_cfg.data;
                    REG_ANGLE_KD_NEAR:   r_akd_near  <= i_cfg.data;
                    REG_POSITION_KP:     r_pkp       <= i_cfg.data;
                    REG_POSITION_KD:     r_pkd       <= i_cfg.data;
                    default: ;
                endcase
            end

            // Drop the result word once the sink takes it; in S_OUT the
            // state logic below owns the valid flag.
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // Latch operands and advance the history.
                        r_ang_err    <= (C_IN_W+1)'(i_in.tilt_angle)
                                      + (C_IN_W+1)'(r_offset);
                        r_ang_der    <= (C_IN_W+1)'(i_in.tilt_angle)
                                      - (C_IN_W+1)'(r_prev_angle);
                        r_pe9        <= (w_perr_ext <<< 3) + w_perr_ext;
                        r_pd9        <= (w_pder_ext <<< 3) + w_pder_ext;
                        r_near       <= w_near;
                        r_prev_angle <= i_in.tilt_angle;
                        r_prev_perr  <= w_perr;
                        r_term       <= 2'd0;
                        r_state      <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mac_done) begin
                        if (r_near || r_term == 2'd3) begin
                            r_state <= S_MAG;
                        end else begin
                            r_term  <= r_term + 2'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_MAG: begin
                    r_neg   <= w_acc[C_ACC_W-1];
                    r_mag   <= w_acc[C_ACC_W-1] ? C_ACC_W'(-w_acc) : w_acc;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_t <= w_rounded[C_ACC_W-1:C_ACC_W-C_Q_W];
                    if (r_near) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= w_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_wv        <= w_cmd;
                        r_out_near  <= r_near;
                        r_out_sat   <= w_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.wheel_velocity = $signed(r_wv);
    assign o_out.near_mode      = r_out_near;
    assign o_out.saturated      = r_out_sat;

endmodule
